/* hw/rtl/sps_pkg.sv */
// sps_pkg: shared constants, codes, control struct and saturating helpers
// for the shortest-remaining-time-first scheduler; no dependencies
package sps_pkg;

  // default sizing
  localparam int MAX_PROCS_DEF  = 16;
  localparam int BURST_BITS_DEF = 16;

  // field widths
  localparam int SLOT_W  = 4;
  localparam int IDENT_W = 8;
  localparam int INBURST_W = 16;
  localparam int BLK_W   = 24;
  localparam int TIME_W  = 32;
  localparam int ACT_W   = 5;
  localparam int PEN_W   = 8;
  localparam int EV_W    = 2;

  // result queue: at most three results per tick
  localparam int QDEPTH = 3;

  // configuration reset values
  localparam logic [ACT_W-1:0] ACTIVE_RESET  = 5'd16;
  localparam logic [PEN_W-1:0] PENALTY_RESET = 8'd1;

  // register indexes
  localparam logic REG_ACTIVE_SLOTS  = 1'b0;
  localparam logic REG_BLOCK_PENALTY = 1'b1;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // event codes
  localparam logic [EV_W-1:0] EV_INTERRUPT = 2'd0;
  localparam logic [EV_W-1:0] EV_DISPATCH  = 2'd1;
  localparam logic [EV_W-1:0] EV_COMPLETE  = 2'd2;
  localparam logic [EV_W-1:0] EV_ALL_DONE  = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } sps_state_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic load;    // write the addressed slot
    logic dec;     // decrement remaining time of the picked slot
    logic charge;  // write new blocked time of the current slot
  } sps_ctl_t;

  // saturating adds
  function automatic logic [TIME_W-1:0] sat_time_add(input logic [TIME_W-1:0] a,
                                                     input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  function automatic logic [BLK_W-1:0] sat_blk_add(input logic [BLK_W-1:0] a,
                                                   input logic [PEN_W-1:0] b);
    logic [BLK_W:0] s;
    s = {1'b0, a} + {{(BLK_W-PEN_W+1){1'b0}}, b};
    return s[BLK_W] ? {BLK_W{1'b1}} : s[BLK_W-1:0];
  endfunction

endpackage

/* hw/rtl/sps_cell.sv */
// sps_cell: one table slot of the scheduler (id, remaining time, blocked time)
// and one stage of the minimum-search chain; uses sps_pkg
module sps_cell #(
  parameter int IDX        = 0,
  parameter int IDXW       = 4,
  parameter int BURST_BITS = sps_pkg::BURST_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sps_pkg::sps_ctl_t            ctl,
  input  logic [sps_pkg::ACT_W-1:0]    active_slots,
  input  logic [sps_pkg::SLOT_W-1:0]   load_slot,
  input  logic [sps_pkg::IDENT_W-1:0]  load_ident,
  input  logic [BURST_BITS-1:0]        load_rem,
  input  logic [IDXW-1:0]              dec_idx,
  input  logic [IDXW-1:0]              cur_idx,
  input  logic                         cur_valid,
  input  logic [sps_pkg::BLK_W-1:0]    charge_blk,
  // search word from the previous cell
  input  logic                         in_valid,
  input  logic                         in_found,
  input  logic [IDXW-1:0]              in_idx,
  input  logic [BURST_BITS-1:0]        in_rem,
  input  logic [sps_pkg::IDENT_W-1:0]  in_ident,
  input  logic [sps_pkg::BLK_W-1:0]    in_blk,
  input  logic [sps_pkg::IDENT_W-1:0]  in_cident,
  input  logic [sps_pkg::BLK_W-1:0]    in_cblk,
  // search word to the next cell
  output logic                         out_valid,
  output logic                         out_found,
  output logic [IDXW-1:0]              out_idx,
  output logic [BURST_BITS-1:0]        out_rem,
  output logic [sps_pkg::IDENT_W-1:0]  out_ident,
  output logic [sps_pkg::BLK_W-1:0]    out_blk,
  output logic [sps_pkg::IDENT_W-1:0]  out_cident,
  output logic [sps_pkg::BLK_W-1:0]    out_cblk
);

  localparam logic [IDXW-1:0] MY_IDX = IDXW'(IDX);

  // slot contents
  logic [sps_pkg::IDENT_W-1:0] ident;
  logic [BURST_BITS-1:0]       rem;
  logic [sps_pkg::BLK_W-1:0]   blk;

  logic active;
  logic take;
  logic is_cur;

  assign active = (32'(active_slots) > IDX);
  assign take   = active && (rem != '0) && (!in_found || (rem < in_rem));
  assign is_cur = cur_valid && (cur_idx == MY_IDX);

  // slot updates: load, decrement of the picked slot, penalty on the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      ident <= '0;
      rem   <= '0;
      blk   <= '0;
    end else begin
      if (ctl.load && (32'(load_slot) == IDX)) begin
        ident <= load_ident;
        rem   <= load_rem;
        blk   <= '0;
      end else begin
        if (ctl.dec && (dec_idx == MY_IDX)) begin
          rem <= rem - BURST_BITS'(1);
        end
        if (ctl.charge && is_cur) begin
          blk <= charge_blk;
        end
      end
    end
  end

  // search word valid travels down the row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // keep the better candidate, pick up the current slot's contents on the way
  always_ff @(posedge clk) begin
    out_found  <= in_found || take;
    out_idx    <= take ? MY_IDX : in_idx;
    out_rem    <= take ? rem    : in_rem;
    out_ident  <= take ? ident  : in_ident;
    out_blk    <= take ? blk    : in_blk;
    out_cident <= is_cur ? ident : in_cident;
    out_cblk   <= is_cur ? blk   : in_cblk;
  end

endmodule

/* hw/rtl/srtf_process_scheduler.sv */
// srtf_process_scheduler: top level with controller, config registers and
// the row of sps_cell slots; uses sps_pkg and sps_cell
//
// Usage:
//   Items enter on start/mode/slot/proc_id/burst_time, taken when start is
//   high and busy is low. A load word (mode 0) writes one slot and yields
//   no result; loads can follow back to back.
//   A tick word (mode 1) sends a search word down the row of MAX_PROCS
//   cells, one cell per cycle starting at the accepting edge; the decision
//   and table update fall when the word leaves the last cell, then zero to
//   three results follow on consecutive cycles, each marked by event_valid
//   for one cycle, the final one with last set.
//   busy stays high through the scan and the results, so no word is taken
//   while a tick is in progress; the length of the cell row sets how long
//   the scan lasts.
//   The receiver cannot stall: results are presented once and not held.
//   Registers active_slots (0x0) and block_penalty (0x4) sit on the APB
//   port, pready is always high; write them only while busy is low.
//   Synchronous reset clears the table, time, current slot and phase,
//   and restores active_slots to 16 and block_penalty to 1.
module srtf_process_scheduler #(
  parameter int MAX_PROCS  = sps_pkg::MAX_PROCS_DEF,
  parameter int BURST_BITS = sps_pkg::BURST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           start,
  output logic                           busy,
  input  logic                           mode,
  input  logic [sps_pkg::SLOT_W-1:0]     slot,
  input  logic [sps_pkg::IDENT_W-1:0]    proc_id,
  input  logic [sps_pkg::INBURST_W-1:0]  burst_time,
  // result channel
  output logic                           event_valid,
  output logic [sps_pkg::EV_W-1:0]       event_res,
  output logic [sps_pkg::SLOT_W-1:0]     event_slot,
  output logic [sps_pkg::IDENT_W-1:0]    event_proc,
  output logic [sps_pkg::TIME_W-1:0]     time_now,
  output logic [sps_pkg::BLK_W-1:0]      blocked_total,
  output logic                           last,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int IDXW = $clog2(MAX_PROCS);

  // slot index to the 4-bit result field
  function automatic logic [sps_pkg::SLOT_W-1:0] to_slot(input logic [IDXW-1:0] idx);
    logic [IDXW+sps_pkg::SLOT_W-1:0] ext;
    ext = {{sps_pkg::SLOT_W{1'b0}}, idx};
    return ext[sps_pkg::SLOT_W-1:0];
  endfunction

  // configuration registers
  logic [sps_pkg::ACT_W-1:0] active_slots;
  logic [sps_pkg::PEN_W-1:0] block_penalty;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots  <= sps_pkg::ACTIVE_RESET;
      block_penalty <= sps_pkg::PENALTY_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        sps_pkg::REG_ACTIVE_SLOTS:  active_slots  <= pwdata[sps_pkg::ACT_W-1:0];
        sps_pkg::REG_BLOCK_PENALTY: block_penalty <= pwdata[sps_pkg::PEN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      sps_pkg::REG_ACTIVE_SLOTS:  prdata = {{(32-sps_pkg::ACT_W){1'b0}}, active_slots};
      sps_pkg::REG_BLOCK_PENALTY: prdata = {{(32-sps_pkg::PEN_W){1'b0}}, block_penalty};
      default:                    prdata = '0;
    endcase
  end

  // scheduler state
  sps_pkg::sps_state_t      state, state_next;
  logic [IDXW-1:0]          cur_idx, cur_idx_next;
  logic                     cur_valid, cur_valid_next;
  logic                     phase, phase_next;
  logic [sps_pkg::TIME_W-1:0] sim_time, sim_time_next;

  logic item_acc;
  logic load_acc;
  logic tick_acc;
  logic decide;

  assign item_acc = start && !busy;
  assign load_acc = item_acc && (mode == sps_pkg::MODE_LOAD);
  assign tick_acc = item_acc && (mode == sps_pkg::MODE_TICK);

  // search chain wires
  logic                         ch_valid  [MAX_PROCS+1];
  logic                         ch_found  [MAX_PROCS+1];
  logic [IDXW-1:0]              ch_idx    [MAX_PROCS+1];
  logic [BURST_BITS-1:0]        ch_rem    [MAX_PROCS+1];
  logic [sps_pkg::IDENT_W-1:0]  ch_ident  [MAX_PROCS+1];
  logic [sps_pkg::BLK_W-1:0]    ch_blk    [MAX_PROCS+1];
  logic [sps_pkg::IDENT_W-1:0]  ch_cident [MAX_PROCS+1];
  logic [sps_pkg::BLK_W-1:0]    ch_cblk   [MAX_PROCS+1];

  assign ch_valid[0]  = tick_acc;
  assign ch_found[0]  = 1'b0;
  assign ch_idx[0]    = '0;
  assign ch_rem[0]    = '0;
  assign ch_ident[0]  = '0;
  assign ch_blk[0]    = '0;
  assign ch_cident[0] = '0;
  assign ch_cblk[0]   = '0;

  // load value masked to the burst width
  logic [BURST_BITS+sps_pkg::INBURST_W-1:0] burst_ext;
  logic [BURST_BITS-1:0]                    load_rem;

  assign burst_ext = {{BURST_BITS{1'b0}}, burst_time};
  assign load_rem  = burst_ext[BURST_BITS-1:0];

  // decision on the search result
  logic                       found;
  logic [IDXW-1:0]            best_idx;
  logic                       intr;
  logic                       disp;
  logic                       comp;
  logic [sps_pkg::BLK_W-1:0]  cur_blk_new;
  logic [sps_pkg::BLK_W-1:0]  best_blk_eff;
  logic [sps_pkg::TIME_W-1:0] t_pen;
  logic [sps_pkg::TIME_W-1:0] t_exec;

  assign found    = ch_found[MAX_PROCS];
  assign best_idx = ch_idx[MAX_PROCS];
  assign decide   = (state == sps_pkg::ST_SCAN) && ch_valid[MAX_PROCS];

  assign intr        = cur_valid && phase;
  assign disp        = intr || !cur_valid || (cur_idx != best_idx);
  assign comp        = (ch_rem[MAX_PROCS] == BURST_BITS'(1));
  assign cur_blk_new = sps_pkg::sat_blk_add(ch_cblk[MAX_PROCS], block_penalty);
  assign best_blk_eff = (intr && (cur_idx == best_idx)) ? cur_blk_new : ch_blk[MAX_PROCS];
  assign t_pen  = intr ? sps_pkg::sat_time_add(sim_time, {24'd0, block_penalty}) : sim_time;
  assign t_exec = sps_pkg::sat_time_add(t_pen, 32'd1);

  // commands to the cells
  sps_pkg::sps_ctl_t ctl;

  assign ctl.load   = load_acc;
  assign ctl.dec    = decide && found;
  assign ctl.charge = decide && found && intr;

  // row of slot cells
  for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
    sps_cell #(
      .IDX       (g),
      .IDXW      (IDXW),
      .BURST_BITS(BURST_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .active_slots(active_slots),
      .load_slot   (slot),
      .load_ident  (proc_id),
      .load_rem    (load_rem),
      .dec_idx     (best_idx),
      .cur_idx     (cur_idx),
      .cur_valid   (cur_valid),
      .charge_blk  (cur_blk_new),
      .in_valid    (ch_valid[g]),
      .in_found    (ch_found[g]),
      .in_idx      (ch_idx[g]),
      .in_rem      (ch_rem[g]),
      .in_ident    (ch_ident[g]),
      .in_blk      (ch_blk[g]),
      .in_cident   (ch_cident[g]),
      .in_cblk     (ch_cblk[g]),
      .out_valid   (ch_valid[g+1]),
      .out_found   (ch_found[g+1]),
      .out_idx     (ch_idx[g+1]),
      .out_rem     (ch_rem[g+1]),
      .out_ident   (ch_ident[g+1]),
      .out_blk     (ch_blk[g+1]),
      .out_cident  (ch_cident[g+1]),
      .out_cblk    (ch_cblk[g+1])
    );
  end

  // result queue
  logic [sps_pkg::EV_W-1:0]    q_res  [sps_pkg::QDEPTH];
  logic [sps_pkg::SLOT_W-1:0]  q_slot [sps_pkg::QDEPTH];
  logic [sps_pkg::IDENT_W-1:0] q_proc [sps_pkg::QDEPTH];
  logic [sps_pkg::TIME_W-1:0]  q_time [sps_pkg::QDEPTH];
  logic [sps_pkg::BLK_W-1:0]   q_blk  [sps_pkg::QDEPTH];
  logic [1:0]                  q_count;

  logic [sps_pkg::EV_W-1:0]    ld_res  [sps_pkg::QDEPTH];
  logic [sps_pkg::SLOT_W-1:0]  ld_slot [sps_pkg::QDEPTH];
  logic [sps_pkg::IDENT_W-1:0] ld_proc [sps_pkg::QDEPTH];
  logic [sps_pkg::TIME_W-1:0]  ld_time [sps_pkg::QDEPTH];
  logic [sps_pkg::BLK_W-1:0]   ld_blk  [sps_pkg::QDEPTH];
  logic [1:0]                  ld_count;
  logic [1:0]                  pos_disp;
  logic [1:0]                  pos_comp;

  assign pos_disp = {1'b0, intr};
  assign pos_comp = {1'b0, intr} + {1'b0, disp};

  // pack the events of this tick in order
  always_comb begin
    for (int i = 0; i < sps_pkg::QDEPTH; i++) begin
      ld_res[i]  = sps_pkg::EV_ALL_DONE;
      ld_slot[i] = '0;
      ld_proc[i] = '0;
      ld_time[i] = sim_time;
      ld_blk[i]  = '0;
    end
    ld_count = 2'd1;
    if (found) begin
      ld_count = {1'b0, intr} + {1'b0, disp} + {1'b0, comp};
      if (intr) begin
        ld_res[0]  = sps_pkg::EV_INTERRUPT;
        ld_slot[0] = to_slot(cur_idx);
        ld_proc[0] = ch_cident[MAX_PROCS];
        ld_time[0] = t_pen;
        ld_blk[0]  = cur_blk_new;
      end
      if (disp) begin
        ld_res[pos_disp]  = sps_pkg::EV_DISPATCH;
        ld_slot[pos_disp] = to_slot(best_idx);
        ld_proc[pos_disp] = ch_ident[MAX_PROCS];
        ld_time[pos_disp] = t_pen;
        ld_blk[pos_disp]  = best_blk_eff;
      end
      if (comp) begin
        ld_res[pos_comp]  = sps_pkg::EV_COMPLETE;
        ld_slot[pos_comp] = to_slot(best_idx);
        ld_proc[pos_comp] = ch_ident[MAX_PROCS];
        ld_time[pos_comp] = t_exec;
        ld_blk[pos_comp]  = best_blk_eff;
      end
    end
  end

  // queue fill on decision, shift on each presented word
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else if (decide) begin
      q_count <= ld_count;
    end else if (event_valid) begin
      q_count <= q_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      for (int i = 0; i < sps_pkg::QDEPTH; i++) begin
        q_res[i]  <= ld_res[i];
        q_slot[i] <= ld_slot[i];
        q_proc[i] <= ld_proc[i];
        q_time[i] <= ld_time[i];
        q_blk[i]  <= ld_blk[i];
      end
    end else if (event_valid) begin
      for (int i = 0; i < sps_pkg::QDEPTH - 1; i++) begin
        q_res[i]  <= q_res[i+1];
        q_slot[i] <= q_slot[i+1];
        q_proc[i] <= q_proc[i+1];
        q_time[i] <= q_time[i+1];
        q_blk[i]  <= q_blk[i+1];
      end
    end
  end

  assign event_res     = q_res[0];
  assign event_slot    = q_slot[0];
  assign event_proc    = q_proc[0];
  assign time_now      = q_time[0];
  assign blocked_total = q_blk[0];
  assign last          = (q_count == 2'd1);

  // current slot, phase and clock after an executed tick
  always_comb begin
    cur_idx_next   = cur_idx;
    cur_valid_next = cur_valid;
    phase_next     = phase;
    sim_time_next  = sim_time;
    if (decide && found) begin
      sim_time_next = t_exec;
      if (comp) begin
        cur_valid_next = 1'b0;
        cur_idx_next   = '0;
      end else begin
        cur_valid_next = 1'b1;
        cur_idx_next   = best_idx;
        phase_next     = !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_idx   <= '0;
      cur_valid <= 1'b0;
      phase     <= 1'b0;
      sim_time  <= '0;
    end else begin
      cur_idx   <= cur_idx_next;
      cur_valid <= cur_valid_next;
      phase     <= phase_next;
      sim_time  <= sim_time_next;
    end
  end

  // controller: next state
  always_comb begin
    state_next = state;
    case (state)
      sps_pkg::ST_IDLE: begin
        if (tick_acc) state_next = sps_pkg::ST_SCAN;
      end
      sps_pkg::ST_SCAN: begin
        if (ch_valid[MAX_PROCS]) begin
          state_next = (ld_count != 2'd0) ? sps_pkg::ST_EMIT : sps_pkg::ST_IDLE;
        end
      end
      sps_pkg::ST_EMIT: begin
        if (q_count == 2'd1) state_next = sps_pkg::ST_IDLE;
      end
      default: state_next = sps_pkg::ST_IDLE;
    endcase
  end

  // controller: outputs
  always_comb begin
    case (state)
      sps_pkg::ST_IDLE: begin
        busy        = 1'b0;
        event_valid = 1'b0;
      end
      sps_pkg::ST_SCAN: begin
        busy        = 1'b1;
        event_valid = 1'b0;
      end
      sps_pkg::ST_EMIT: begin
        busy        = 1'b1;
        event_valid = 1'b1;
      end
      default: begin
        busy        = 1'b0;
        event_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // the final word of a tick is followed by an idle result channel
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    event_valid && last |=> !event_valid)
    else $error("result after final word of a tick");

  // the search word reaches the row end only while a tick is scanning
  a_chain_scan: assert property (@(posedge clk) disable iff (rst)
    ch_valid[MAX_PROCS] |-> (state == sps_pkg::ST_SCAN))
    else $error("search word at row end outside scan");

  // results begin only right after a decision
  a_emit_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(event_valid) |-> ($past(state) == sps_pkg::ST_SCAN))
    else $error("results started without a decision");

  // the current slot always names a real cell
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (32'(cur_idx) < MAX_PROCS))
    else $error("current slot out of range");
`endif

endmodule

/* test/srtf_process_scheduler_tb.sv */
// srtf_process_scheduler_tb: self-checking testbench for the srtf scheduler;
// predicts every event word from its own table copy and checks each field
// depends on sps_pkg and the srtf_process_scheduler rtl
module srtf_process_scheduler_tb;

  localparam int NSLOTS       = sps_pkg::MAX_PROCS_DEF;
  // longest tick keeps the block busy for the row scan plus three results; rest is slack
  localparam int DRAIN_CYCLES = NSLOTS + 1 + 3 + 4;
  localparam int LIMIT_TIME   = 4_000_000;

  localparam logic [2:0] ADDR_ACTIVE  = {sps_pkg::REG_ACTIVE_SLOTS, 2'b00};
  localparam logic [2:0] ADDR_PENALTY = {sps_pkg::REG_BLOCK_PENALTY, 2'b00};

  typedef struct {
    logic        m;
    logic [3:0]  s;
    logic [7:0]  id;
    logic [15:0] b;
    int          gap;
  } sched_word_t;

  typedef struct {
    logic [1:0]  res;
    logic [3:0]  slot;
    logic [7:0]  proc;
    logic [31:0] tnow;
    logic [23:0] blk;
    logic        last;
  } sched_event_t;

  // clock and dut signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [3:0]  slot = '0;
  logic [7:0]  proc_id = '0;
  logic [15:0] burst_time = '0;
  logic        event_valid;
  logic [1:0]  event_res;
  logic [3:0]  event_slot;
  logic [7:0]  event_proc;
  logic [31:0] time_now;
  logic [23:0] blocked_total;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted scheduler state
  logic [15:0] rem_tab [NSLOTS];
  logic [7:0]  ident_tab [NSLOTS];
  logic [23:0] blk_tab [NSLOTS];
  int          cur_slot;
  bit          cur_valid;
  bit          phase_bit;
  logic [31:0] clock_now;
  logic [4:0]  act_cfg;
  logic [7:0]  pen_cfg;

  sched_word_t  pending_words[$];
  sched_event_t exp_events[$];
  sched_event_t want_ev;
  logic         word_taken = 1'b0;
  int           gap_count = 0;
  int           errors = 0;
  int           loads_seen = 0;
  int           ticks_seen = 0;
  int           results_seen = 0;
  int           irq_seen = 0;

  srtf_process_scheduler dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .mode(mode), .slot(slot), .proc_id(proc_id), .burst_time(burst_time),
    .event_valid(event_valid), .event_res(event_res), .event_slot(event_slot),
    .event_proc(event_proc), .time_now(time_now), .blocked_total(blocked_total),
    .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at %0t: got %0h expected %0h", what, $time, got, want);
    errors++;
  endtask

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // event word built from the current table state; slot NSLOTS means none
  function automatic sched_event_t make_event(input logic [1:0] code, input int s);
    sched_event_t e;
    e.res  = code;
    e.tnow = clock_now;
    e.last = 1'b0;
    if (s < NSLOTS) begin
      e.slot = 4'(s);
      e.proc = ident_tab[s];
      e.blk  = blk_tab[s];
    end else begin
      e.slot = '0;
      e.proc = '0;
      e.blk  = '0;
    end
    return e;
  endfunction

  // srtf prediction for one accepted word
  task automatic predict_word(input logic m, input logic [3:0] s, input logic [7:0] id,
                              input logic [15:0] b);
    sched_event_t ev [3];
    int           k;
    int           n;
    int           best;
    logic [15:0]  best_rem;
    bit           found;
    logic [24:0]  blk_sum;
    k = 0;
    found = 0;
    best = 0;
    best_rem = '0;
    if (m == sps_pkg::MODE_LOAD) begin
      ident_tab[s] = id;
      rem_tab[s] = b;
      blk_tab[s] = '0;
      loads_seen++;
    end else begin
      ticks_seen++;
      n = (act_cfg > NSLOTS) ? NSLOTS : int'(act_cfg);
      for (int i = 0; i < n; i++) begin
        if (rem_tab[i] != 0 && (!found || rem_tab[i] < best_rem)) begin
          found = 1;
          best_rem = rem_tab[i];
          best = i;
        end
      end
      if (!found) begin
        ev[0] = make_event(sps_pkg::EV_ALL_DONE, NSLOTS);
        k = 1;
      end else begin
        rem_tab[best] = rem_tab[best] - 16'd1;
        // blocking penalty on the running process
        if (cur_valid && phase_bit) begin
          blk_sum = {1'b0, blk_tab[cur_slot]} + 25'(pen_cfg);
          blk_tab[cur_slot] = blk_sum[24] ? 24'hFF_FFFF : blk_sum[23:0];
          clock_now = add_sat32(clock_now, 32'(pen_cfg));
          ev[k] = make_event(sps_pkg::EV_INTERRUPT, cur_slot);
          k++;
          cur_valid = 0;
        end
        if (!cur_valid || cur_slot != best) begin
          cur_slot = best;
          cur_valid = 1;
          ev[k] = make_event(sps_pkg::EV_DISPATCH, best);
          k++;
        end
        clock_now = add_sat32(clock_now, 32'd1);
        if (rem_tab[best] == 0) begin
          ev[k] = make_event(sps_pkg::EV_COMPLETE, best);
          k++;
          cur_valid = 0;
          cur_slot = NSLOTS;
        end
        if (cur_valid) phase_bit = ~phase_bit;
      end
      // a tick that keeps the same process running reports nothing
      if (k > 0) ev[k-1].last = 1'b1;
      for (int i = 0; i < k; i++) exp_events.push_back(ev[i]);
    end
  endtask

  // acceptance tracking and event checking
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (event_valid) begin
        results_seen++;
        if (event_res == sps_pkg::EV_INTERRUPT) irq_seen++;
        if (exp_events.size() == 0) begin
          report_mismatch("event with none expected", 32'(event_res), 32'hFFFF_FFFF);
        end else begin
          want_ev = exp_events.pop_front();
          if (event_res !== want_ev.res)
            report_mismatch("event_res", 32'(event_res), 32'(want_ev.res));
          if (event_slot !== want_ev.slot)
            report_mismatch("event_slot", 32'(event_slot), 32'(want_ev.slot));
          if (event_proc !== want_ev.proc)
            report_mismatch("event_proc", 32'(event_proc), 32'(want_ev.proc));
          if (time_now !== want_ev.tnow) report_mismatch("time_now", time_now, want_ev.tnow);
          if (blocked_total !== want_ev.blk)
            report_mismatch("blocked_total", 32'(blocked_total), 32'(want_ev.blk));
          if (last !== want_ev.last) report_mismatch("last", 32'(last), 32'(want_ev.last));
        end
      end
      if (start && !busy) predict_word(mode, slot, proc_id, burst_time);
    end
  end

  // word driver: holds start until taken, then idles for the next word's gap
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_count <= 0;
    end else if (!start || word_taken) begin
      if (pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (gap_count < pending_words[0].gap) begin
        start <= 1'b0;
        gap_count <= gap_count + 1;
      end else begin
        start <= 1'b1;
        mode <= pending_words[0].m;
        slot <= pending_words[0].s;
        proc_id <= pending_words[0].id;
        burst_time <= pending_words[0].b;
        gap_count <= 0;
        void'(pending_words.pop_front());
      end
    end
  end

  function automatic int pick_gap(input bit tight);
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_word(input logic m, input logic [3:0] s, input logic [7:0] id,
                           input logic [15:0] b, input bit tight);
    sched_word_t w;
    w.m = m;
    w.s = s;
    w.id = id;
    w.b = b;
    w.gap = pick_gap(tight);
    pending_words.push_back(w);
  endtask

  task automatic push_tick(input bit tight);
    push_word(sps_pkg::MODE_TICK, 4'($urandom), 8'($urandom), 16'($urandom), tight);
  endtask

  // random part: mostly load-then-run sequences, some noise words
  task automatic gen_random(input int count);
    int  made;
    int  r;
    int  lim;
    int  nload;
    int  nticks;
    int  b;
    bit  tight;
    logic [3:0] s;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 9);
      tight = ($urandom_range(0, 2) == 0);
      lim = (act_cfg == 0 || act_cfg > NSLOTS) ? NSLOTS : int'(act_cfg);
      if (r < 7) begin
        if (r < 2) begin
          for (int i = 0; i < lim; i++) begin
            push_word(sps_pkg::MODE_LOAD, 4'(i), 8'($urandom), 16'd0, tight);
            made++;
          end
        end
        nload = $urandom_range(1, 4);
        nticks = 0;
        for (int i = 0; i < nload; i++) begin
          s = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, lim - 1));
          b = $urandom_range(1, 5);
          nticks += b;
          push_word(sps_pkg::MODE_LOAD, s, 8'($urandom), 16'(b), tight);
          made++;
        end
        nticks += $urandom_range(1, 2);
        for (int i = 0; i < nticks; i++) begin
          push_tick(tight);
          made++;
        end
      end else if (r == 7) begin
        push_word(sps_pkg::MODE_LOAD, 4'($urandom), 8'($urandom), 16'($urandom), tight);
        made++;
      end else if (r == 8) begin
        push_tick(tight);
        made++;
      end else begin
        push_word(sps_pkg::MODE_LOAD, 4'($urandom), 8'($urandom),
                  16'($urandom_range(0, 3)), tight);
        made++;
      end
    end
  endtask

  // wait until every word is taken and every event has come, then let the block settle
  task automatic drain();
    while (pending_words.size() != 0 || start || exp_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write both registers while idle and read them back
  task automatic set_regs(input logic [4:0] act, input logic [7:0] pen);
    logic [31:0] rd;
    apb_xfer(1'b1, ADDR_ACTIVE, 32'(act), rd);
    apb_xfer(1'b1, ADDR_PENALTY, 32'(pen), rd);
    act_cfg = act;
    pen_cfg = pen;
    apb_xfer(1'b0, ADDR_ACTIVE, 32'd0, rd);
    if (rd !== 32'(act)) report_mismatch("active_slots readback", rd, 32'(act));
    apb_xfer(1'b0, ADDR_PENALTY, 32'd0, rd);
    if (rd !== 32'(pen)) report_mismatch("block_penalty readback", rd, 32'(pen));
  endtask

  // run limit
  initial begin
    #(LIMIT_TIME);
    $display("FAILURE");
    $finish;
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < NSLOTS; i++) begin
      rem_tab[i] = '0;
      ident_tab[i] = '0;
      blk_tab[i] = '0;
    end
    cur_slot = NSLOTS;
    cur_valid = 0;
    phase_bit = 0;
    clock_now = '0;
    act_cfg = sps_pkg::ACTIVE_RESET;
    pen_cfg = sps_pkg::PENALTY_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: empty table, ties, interrupts, load over the running slot, all done
    push_tick(0);
    push_word(sps_pkg::MODE_LOAD, 4'd0, 8'hFF, 16'd2, 0);
    push_word(sps_pkg::MODE_LOAD, 4'd3, 8'h00, 16'd2, 0);
    push_word(sps_pkg::MODE_LOAD, 4'd15, 8'hA5, 16'hFFFF, 0);
    repeat (5) push_tick(0);
    push_word(sps_pkg::MODE_LOAD, 4'd15, 8'h5A, 16'd0, 0);
    push_word(sps_pkg::MODE_LOAD, 4'd7, 8'h3C, 16'd1, 0);
    repeat (2) push_tick(0);
    push_word(sps_pkg::MODE_LOAD, 4'd2, 8'h81, 16'd3, 1);
    push_word(sps_pkg::MODE_LOAD, 4'd1, 8'h7E, 16'd4, 1);
    repeat (8) push_tick(1);
    drain();

    // random phases over several register settings
    set_regs(5'd1, 8'd255);
    gen_random(15);
    drain();
    set_regs(5'd16, 8'd0);
    gen_random(15);
    drain();
    set_regs(5'd31, 8'($urandom_range(2, 254)));
    gen_random(15);
    drain();
    set_regs(5'd0, 8'($urandom));
    gen_random(5);
    drain();
    set_regs(5'($urandom_range(2, 15)), 8'($urandom));
    gen_random(12);
    drain();

    if (exp_events.size() != 0)
      report_mismatch("events never seen", 32'(exp_events.size()), 32'd0);
    $display("run covered %0d loads and %0d ticks, %0d event words with %0d interrupts,",
             loads_seen, ticks_seen, results_seen, irq_seen);
    $display("over six register settings including zero and oversized slot counts");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
